[design/command_line_tokenizer_unit_assert.svh]
// Assertion macros for the command line tokenizer.
// Used by the top level; no other dependencies.
`ifndef COMMAND_LINE_TOKENIZER_UNIT_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CLT_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CLT_ASSERT_SAME(label, clk, rst_n, pre, post, msg)
`define CLT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

[design/clt_pkg.sv]
// Shared types, codes and sizes of the command line tokenizer.
// No dependencies; imported by clt_step and the top level.
`timescale 1ns / 1ps

package clt_pkg;

    localparam int NAME_LEN  = 16;
    localparam int VALUE_LEN = 16;
    localparam int MAX_SLOTS = 8;
    localparam int LINE_LEN  = 64;

    localparam int NPOS_W = $clog2(NAME_LEN + 1);
    localparam int VPOS_W = $clog2(VALUE_LEN);
    localparam int LLEN_W = $clog2(LINE_LEN + 1);

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_EQUALS  = 8'd61;

    localparam logic [2:0] KIND_NAME_CHAR = 3'd0;
    localparam logic [2:0] KIND_TAG       = 3'd1;
    localparam logic [2:0] KIND_VALUE     = 3'd2;
    localparam logic [2:0] KIND_VALUE_END = 3'd3;
    localparam logic [2:0] KIND_LINE_END  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NAME_LONG  = 3'd1;
    localparam logic [2:0] ST_MALFORMED  = 3'd2;
    localparam logic [2:0] ST_VALUE_LONG = 3'd3;
    localparam logic [2:0] ST_TOO_MANY   = 3'd4;
    localparam logic [2:0] ST_LINE_LONG  = 3'd5;

    typedef enum logic [3:0] {
        PH_NAME  = 4'b0001,
        PH_VALUE = 4'b0010,
        PH_TAG   = 4'b0100,
        PH_SKIP  = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [NPOS_W-1:0]   name_pos;
        logic [2:0]          slot_index;
        logic [VPOS_W-1:0]   value_pos;
        logic [LLEN_W-1:0]   line_len;
        logic [2:0]          error_code;
    } t_state;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] slot;
        logic [5:0] position;
        logic [7:0] char_out;
        logic [2:0] status;
        logic [3:0] param_count;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:      PH_NAME,
        name_pos:   '0,
        slot_index: '0,
        value_pos:  '0,
        line_len:   '0,
        error_code: ST_OK
    };

endpackage

[design/clt_step.sv]
// Next-state and result logic of the tokenizer for one received byte.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_step (
    input  clt_pkg::t_state  i_cur,
    input  logic [7:0]       i_byte,
    output clt_pkg::t_state  o_nxt,
    output logic             o_emit,
    output clt_pkg::t_result o_res
);
    import clt_pkg::*;

    always_comb begin
        o_nxt  = i_cur;
        o_emit = 1'b0;
        o_res  = '0;

        if (i_byte == CH_NEWLINE) begin
            o_emit           = 1'b1;
            o_res.kind       = KIND_LINE_END;
            o_res.status     = i_cur.error_code;
            o_res.param_count = (i_cur.phase == PH_NAME) ? 4'd0
                                : 4'(i_cur.slot_index) + 4'd1;
            // A line that ends inside a tag is malformed unless it already failed.
            if (i_cur.error_code == ST_OK &&
                (i_cur.phase == PH_TAG || i_cur.phase == PH_SKIP)) begin
                o_res.status = ST_MALFORMED;
            end
            o_nxt = STATE_RESET;
        end else if (i_cur.error_code != ST_OK) begin
            o_nxt = i_cur;
        end else if (i_cur.line_len >= LLEN_W'(LINE_LEN)) begin
            o_nxt.error_code = ST_LINE_LONG;
        end else begin
            o_nxt.line_len = i_cur.line_len + LLEN_W'(1);
            case (i_cur.phase)
                PH_NAME: begin
                    if (i_cur.name_pos >= NPOS_W'(NAME_LEN)) begin
                        o_nxt.error_code = ST_NAME_LONG;
                    end else if (i_byte == CH_SPACE) begin
                        o_nxt.phase = PH_VALUE;
                    end else begin
                        o_emit         = 1'b1;
                        o_res.kind     = KIND_NAME_CHAR;
                        o_res.position = 6'(i_cur.name_pos);
                        o_res.char_out = i_byte;
                        o_nxt.name_pos = i_cur.name_pos + NPOS_W'(1);
                    end
                end
                PH_TAG: begin
                    o_emit         = 1'b1;
                    o_res.kind     = KIND_TAG;
                    o_res.slot     = i_cur.slot_index;
                    o_res.char_out = i_byte;
                    o_nxt.phase    = PH_SKIP;
                end
                PH_SKIP: begin
                    o_nxt.phase = PH_VALUE;
                end
                default: begin
                    if (i_byte == CH_SPACE) begin
                        if (4'(i_cur.slot_index) + 4'd1 >= 4'(MAX_SLOTS)) begin
                            o_nxt.error_code = ST_TOO_MANY;
                        end else begin
                            o_emit           = 1'b1;
                            o_res.kind       = KIND_VALUE_END;
                            o_res.slot       = i_cur.slot_index;
                            o_res.position   = 6'(i_cur.value_pos);
                            o_nxt.slot_index = i_cur.slot_index + 3'd1;
                            o_nxt.value_pos  = '0;
                        end
                    end else if (i_byte == CH_EQUALS) begin
                        o_nxt.phase = PH_TAG;
                    end else if (i_cur.value_pos >= VPOS_W'(VALUE_LEN - 1)) begin
                        o_nxt.error_code = ST_VALUE_LONG;
                    end else begin
                        o_emit          = 1'b1;
                        o_res.kind      = KIND_VALUE;
                        o_res.slot      = i_cur.slot_index;
                        o_res.position  = 6'(i_cur.value_pos);
                        o_res.char_out  = i_byte;
                        o_nxt.value_pos = i_cur.value_pos + VPOS_W'(1);
                    end
                end
            endcase
        end
    end

endmodule

[design/command_line_tokenizer_unit.sv]
// Top level of the command line tokenizer: state, output register and skid stage.
// Depends on clt_pkg, clt_step and command_line_tokenizer_unit_assert.svh.
`timescale 1ns / 1ps

// The tokenizer takes one received byte per cycle unless stalled and splits
// each newline-ended line into a command name and up to eight parameter slots,
// giving at most one result per byte. The whole update runs through the single
// clt_step stage, so the sustained rate is one byte per clock unless stalled.
// Results pass through an output register backed by a one-entry skid stage:
// o_stall rises only when both hold results, so input keeps flowing for one
// extra result while the output is stalled.
`include "command_line_tokenizer_unit_assert.svh"

module command_line_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [2:0] o_slot,
    output logic [5:0] o_position,
    output logic [7:0] o_char_out,
    output logic [2:0] o_status,
    output logic [3:0] o_param_count
);
    import clt_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    t_state  step_nxt;
    logic    step_emit;
    t_result step_res;
    logic    in_accept;
    logic    out_taken;

    clt_step u_step (
        .i_cur  (r_state),
        .i_byte (i_rx_byte),
        .o_nxt  (step_nxt),
        .o_emit (step_emit),
        .o_res  (step_res)
    );

    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign out_taken = r_out_valid && !i_stall;

    always_comb begin
        n_state      = in_accept ? step_nxt : r_state;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_taken) begin
            n_out_valid  = r_skid_valid;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end
        // A new result goes to the output register if it is free, else to the skid.
        if (in_accept && step_emit) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = step_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = step_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= STATE_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_slot        = r_out.slot;
    assign o_position    = r_out.position;
    assign o_char_out    = r_out.char_out;
    assign o_status      = r_out.status;
    assign o_param_count = r_out.param_count;

    `CLT_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full while output empty")
    `CLT_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && i_stall, r_skid_valid, "skid result lost under stall")
    `CLT_ASSERT_NEXT(a_newline_clears, i_clk, i_rst_n, in_accept && i_rx_byte == CH_NEWLINE, r_state == STATE_RESET, "line state not cleared after newline")
    `CLT_ASSERT_SAME(a_error_silent, i_clk, i_rst_n, r_state.error_code != ST_OK && i_rx_byte != CH_NEWLINE, !step_emit, "result produced after a line error")

endmodule

[dv/command_line_tokenizer_unit_test.sv]
// Self-checking testbench for the command line tokenizer: directed and random lines.
// A built-in predictor models the block; depends on clt_pkg and the design files.
`timescale 1ns / 1ps

module command_line_tokenizer_unit_test;
    import clt_pkg::*;

    localparam int RANDOM_BYTES = 1500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_FROM   = 800;
    localparam int QUIET_TO     = 1400;
    localparam int IDLE_PCT     = 36;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_kind;
    logic [2:0] o_slot;
    logic [5:0] o_position;
    logic [7:0] o_char_out;
    logic [2:0] o_status;
    logic [3:0] o_param_count;

    command_line_tokenizer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_slot        (o_slot),
        .o_position    (o_position),
        .o_char_out    (o_char_out),
        .o_status      (o_status),
        .o_param_count (o_param_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    logic [7:0] rx_plan[$];
    t_result    expected_tokens[$];
    int         cycle_count = 0;
    int         mismatches = 0;
    int         bytes_sent = 0;
    int         results_checked = 0;
    int         lines_planned = 0;
    int         status_seen[8];

    // Tokenizer state as the predictor tracks it.
    t_phase     ph = PH_NAME;
    int         name_idx = 0;
    int         slot_idx = 0;
    int         val_idx = 0;
    int         line_cnt = 0;
    logic [2:0] err = ST_OK;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit quiet_window();
        return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
    endfunction

    task automatic clear_line_state();
        ph       = PH_NAME;
        name_idx = 0;
        slot_idx = 0;
        val_idx  = 0;
        line_cnt = 0;
        err      = ST_OK;
    endtask

    task automatic push_token(input logic [2:0] kind, input int slot, input int pos,
                              input logic [7:0] ch);
        t_result r;
        r          = '0;
        r.kind     = kind;
        r.slot     = 3'(slot);
        r.position = 6'(pos);
        r.char_out = ch;
        expected_tokens.push_back(r);
    endtask

    // Advances the predicted state by one accepted byte and queues its result.
    task automatic tokenize_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        if (b == CH_NEWLINE) begin
            r.kind        = KIND_LINE_END;
            r.status      = err;
            if (err == ST_OK && (ph == PH_TAG || ph == PH_SKIP))
                r.status = ST_MALFORMED;
            r.param_count = (ph == PH_NAME) ? 4'd0 : 4'(slot_idx + 1);
            expected_tokens.push_back(r);
            status_seen[r.status]++;
            clear_line_state();
        end else if (err == ST_OK) begin
            if (line_cnt >= LINE_LEN) begin
                err = ST_LINE_LONG;
            end else begin
                line_cnt++;
                case (ph)
                    PH_NAME: begin
                        if (name_idx >= NAME_LEN) begin
                            err = ST_NAME_LONG;
                        end else if (b == CH_SPACE) begin
                            ph = PH_VALUE;
                        end else begin
                            push_token(KIND_NAME_CHAR, 0, name_idx, b);
                            name_idx++;
                        end
                    end
                    PH_TAG: begin
                        push_token(KIND_TAG, slot_idx, 0, b);
                        ph = PH_SKIP;
                    end
                    PH_SKIP: begin
                        ph = PH_VALUE;
                    end
                    default: begin
                        if (b == CH_SPACE) begin
                            if (slot_idx + 1 >= MAX_SLOTS) begin
                                err = ST_TOO_MANY;
                            end else begin
                                push_token(KIND_VALUE_END, slot_idx, val_idx, 8'd0);
                                slot_idx++;
                                val_idx = 0;
                            end
                        end else if (b == CH_EQUALS) begin
                            ph = PH_TAG;
                        end else if (val_idx >= VALUE_LEN - 1) begin
                            err = ST_VALUE_LONG;
                        end else begin
                            push_token(KIND_VALUE, slot_idx, val_idx, b);
                            val_idx++;
                        end
                    end
                endcase
            end
        end
    endtask

    // ---------------- stimulus planning ----------------

    task automatic plan_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rx_plan.push_back(s[i]);
    endtask

    task automatic end_line();
        rx_plan.push_back(CH_NEWLINE);
        lines_planned++;
    endtask

    // Any byte but newline, space and equals.
    function automatic logic [7:0] pick_value_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_NEWLINE || b == CH_SPACE || b == CH_EQUALS)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] pick_non_newline();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_NEWLINE)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic plan_name(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = pick_non_newline();
            if (b == CH_SPACE)
                b = "n";
            rx_plan.push_back(b);
        end
    endtask

    task automatic plan_value(input int len);
        for (int i = 0; i < len; i++)
            rx_plan.push_back(pick_value_char());
    endtask

    task automatic plan_random_line();
        int mode;
        int nlen;
        int nslots;
        int vmax;
        mode = $urandom_range(0, 99);
        if (mode < 8) begin
            // Raw noise, which may hold newlines of its own.
            repeat ($urandom_range(1, 20))
                rx_plan.push_back(8'($urandom_range(0, 255)));
            end_line();
        end else begin
            nlen = ($urandom_range(0, 9) == 0) ? NAME_LEN + $urandom_range(0, 2)
                                               : $urandom_range(0, 6);
            plan_name(nlen);
            vmax = (mode < 20) ? VALUE_LEN : 5;
            if ($urandom_range(0, 4) != 0) begin
                rx_plan.push_back(CH_SPACE);
                nslots = ($urandom_range(0, 9) == 0) ? MAX_SLOTS + $urandom_range(0, 1)
                                                     : $urandom_range(1, 4);
                if (mode < 20)
                    nslots = $urandom_range(4, MAX_SLOTS);
                for (int s = 0; s < nslots; s++) begin
                    if (s > 0)
                        rx_plan.push_back(CH_SPACE);
                    if ($urandom_range(0, 2) == 0) begin
                        rx_plan.push_back(CH_EQUALS);
                        rx_plan.push_back(pick_non_newline());
                        rx_plan.push_back(pick_non_newline());
                    end
                    if ($urandom_range(0, 11) == 0)
                        plan_value(VALUE_LEN - 1 + $urandom_range(0, 1));
                    else
                        plan_value($urandom_range(0, vmax));
                end
                // Occasionally cut the line off inside a tag.
                if ($urandom_range(0, 19) == 0) begin
                    rx_plan.push_back(CH_EQUALS);
                    if ($urandom_range(0, 1) == 1)
                        rx_plan.push_back(pick_non_newline());
                end
            end
            end_line();
        end
    endtask

    task automatic plan_directed();
        end_line();                          // empty line
        plan_text("ab");
        end_line();                          // name only, no slots
        plan_text("ab ");
        end_line();                          // one empty slot
        plan_text("x =k:v1 w");
        end_line();                          // tag, skipped byte, values
        rx_plan.push_back(8'hFF);
        rx_plan.push_back(8'h00);
        rx_plan.push_back(CH_SPACE);
        rx_plan.push_back(8'h00);
        rx_plan.push_back(8'hFF);
        end_line();                          // extreme byte values
        plan_name(NAME_LEN + 1);
        end_line();                          // name one too long
        plan_name(NAME_LEN);
        plan_text(" ");
        end_line();                          // space past the name limit
        plan_text("c =");
        end_line();                          // line ends before the tag letter
        plan_text("c =k");
        end_line();                          // line ends before the skipped byte
        plan_text("c ");
        plan_value(VALUE_LEN);
        end_line();                          // value one too long
        plan_text("c ");
        repeat (MAX_SLOTS - 1) rx_plan.push_back(CH_SPACE);
        end_line();                          // every slot used
        plan_text("c ");
        repeat (MAX_SLOTS) rx_plan.push_back(CH_SPACE);
        end_line();                          // one slot too many
        // Exactly LINE_LEN bytes, then the same line with one byte more.
        for (int extra = 0; extra < 2; extra++) begin
            plan_name(NAME_LEN);
            rx_plan.push_back(CH_SPACE);
            for (int s = 0; s < 3; s++) begin
                if (s > 0)
                    rx_plan.push_back(CH_SPACE);
                plan_value(VALUE_LEN - 1);
            end
            if (extra == 1)
                rx_plan.push_back(pick_value_char());
            end_line();
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                tokenize_byte(i_rx_byte);
                bytes_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (rx_plan.size() != 0 &&
                    (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_valid   <= 1'b1;
                    i_rx_byte <= rx_plan.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic compare_field(input string fname, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: result with nothing expected, kind %0d char %0d",
                             $time, o_kind, o_char_out);
                    mismatches++;
                end else begin
                    want = expected_tokens.pop_front();
                    compare_field("kind", want.kind, o_kind);
                    compare_field("slot", want.slot, o_slot);
                    compare_field("position", want.position, o_position);
                    compare_field("char_out", want.char_out, o_char_out);
                    compare_field("status", want.status, o_status);
                    compare_field("param_count", want.param_count, o_param_count);
                    results_checked++;
                end
            end
            i_stall <= !quiet_window() && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ---------------- sequencing ----------------

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("Timed out with %0d results still expected", expected_tokens.size());
        $display("command_line_tokenizer_unit test failed");
        $finish;
    end

    initial begin
        int base;
        plan_directed();
        base = rx_plan.size();
        while (rx_plan.size() - base < RANDOM_BYTES)
            plan_random_line();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Checked at the falling edge, once the clocked updates have settled.
        while (rx_plan.size() != 0 || i_valid)
            @(negedge i_clk);
        while (expected_tokens.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes over %0d planned lines; %0d results checked.",
                 bytes_sent, lines_planned, results_checked);
        $display("Line ends by status: ok %0d, name %0d, tag %0d, value %0d, slots %0d, line %0d",
                 status_seen[ST_OK], status_seen[ST_NAME_LONG], status_seen[ST_MALFORMED],
                 status_seen[ST_VALUE_LONG], status_seen[ST_TOO_MANY],
                 status_seen[ST_LINE_LONG]);
        if (mismatches == 0)
            $display("command_line_tokenizer_unit test passed");
        else
            $display("command_line_tokenizer_unit test failed");
        $finish;
    end

endmodule
